>>> src/cda_pkg.sv
`timescale 1ns / 1ps

package cda_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned Q100_W  = 8;   // year / 100 for any 14-bit year
  localparam int unsigned R100_W  = 7;
  localparam int unsigned ZSUM_W  = 11;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MON_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR   = 4'd3;
  localparam logic [MONTH_W-1:0] MON_DEC   = 4'd12;
  localparam logic [MONTH_W-1:0] MON_JAN   = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_JAN_LEN = 5'd31;

  // floor(x / 100) = (x * 5243) >> 19 for x < 2^14
  localparam int unsigned RECIP100_MUL = 5243;
  localparam int unsigned RECIP100_SH  = 19;
  localparam int unsigned PROD100_W    = 27;
  // floor(x / 7) = (x * 4682) >> 15 for x < 2^11
  localparam int unsigned RECIP7_MUL   = 4682;
  localparam int unsigned RECIP7_SH    = 15;
  localparam int unsigned PROD7_W      = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_DAY   = 3'd0,
    OP_ADD_MONTH = 3'd1,
    OP_ADD_YEAR  = 3'd2,
    OP_WEEKDAY   = 3'd3,
    OP_NEXT_MON  = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [YEAR_W-1:0]  yz;
    logic [MONTH_W-1:0] mz;
    logic [Q100_W-1:0]  qy;
    logic [Q100_W-1:0]  qz;
  } s1_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   len_nm;
    logic [DAY_W-1:0]   len_ny;
    logic [ZSUM_W-1:0]  h;
    logic               bad;
  } s2_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   len_nm;
    logic [DAY_W-1:0]   len_ny;
    logic [WDAY_W-1:0]  wd;
    logic               bad;
  } s3_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
    logic               bad;
  } res_t;

  function automatic logic [DAY_W-1:0] month_len(input logic lp, input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
        4'd2:                                        len = lp ? 5'd29 : 5'd28;
        default:                                     len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // floor(13 * (mz + 1) / 5) for the shifted month 3..14
  function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] mz);
    logic [5:0] v;
    begin
      unique case (mz)
        4'd3:    v = 6'd10;
        4'd4:    v = 6'd13;
        4'd5:    v = 6'd15;
        4'd6:    v = 6'd18;
        4'd7:    v = 6'd20;
        4'd8:    v = 6'd23;
        4'd9:    v = 6'd26;
        4'd10:   v = 6'd28;
        4'd11:   v = 6'd31;
        4'd12:   v = 6'd33;
        4'd13:   v = 6'd36;
        4'd14:   v = 6'd39;
        default: v = 6'd0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> src/cda_calc.sv
`timescale 1ns / 1ps

module cda_calc (
  input  cda_pkg::s3_t  s3_i,
  output cda_pkg::res_t res_o
);
  import cda_pkg::*;

  logic [YEAR_W-1:0]  y_nxt;
  logic [MONTH_W-1:0] m_nxt;
  logic [DAY_W-1:0]   d_nxt;
  logic [MONTH_W-1:0] m_inc;
  logic               dec;
  logic [DAY_W:0]     d_mon;
  logic [DAY_W:0]     len_ext;
  logic [WDAY_W:0]    mon_step;

  assign dec      = (s3_i.m == MON_DEC);
  assign m_inc    = dec ? MON_JAN : (s3_i.m + MON_JAN);
  assign mon_step = (s3_i.wd == '0) ? 4'd1 : (4'd8 - {1'b0, s3_i.wd});
  assign d_mon    = {1'b0, s3_i.d} + {{(DAY_W-WDAY_W){1'b0}}, mon_step};
  assign len_ext  = {1'b0, s3_i.len};

  always_comb begin
    y_nxt = s3_i.y;
    m_nxt = s3_i.m;
    d_nxt = s3_i.d;
    if (!s3_i.bad) begin
      unique case (op_t'(s3_i.op))
        OP_ADD_DAY: begin
          if (s3_i.d < s3_i.len) begin
            d_nxt = s3_i.d + DAY_FIRST;
          end else begin
            y_nxt = dec ? (s3_i.y + 14'd1) : s3_i.y;
            m_nxt = m_inc;
            d_nxt = DAY_FIRST;
          end
        end
        OP_ADD_MONTH: begin
          y_nxt = dec ? (s3_i.y + 14'd1) : s3_i.y;
          m_nxt = m_inc;
          if (s3_i.d > s3_i.len_nm) d_nxt = s3_i.len_nm;
        end
        OP_ADD_YEAR: begin
          y_nxt = s3_i.y + 14'd1;
          if (s3_i.d > s3_i.len_ny) d_nxt = s3_i.len_ny;
        end
        OP_NEXT_MON: begin
          if (d_mon > len_ext) begin
            d_nxt = DAY_W'(d_mon - len_ext);
            y_nxt = dec ? (s3_i.y + 14'd1) : s3_i.y;
            m_nxt = m_inc;
          end else begin
            d_nxt = d_mon[DAY_W-1:0];
          end
        end
        default: begin
          d_nxt = s3_i.d;
        end
      endcase
    end
  end

  assign res_o.year    = y_nxt;
  assign res_o.month   = m_nxt;
  assign res_o.day     = d_nxt;
  assign res_o.weekday = s3_i.bad ? '0 : s3_i.wd;
  assign res_o.bad     = s3_i.bad || (y_nxt > YEAR_MAX);

endmodule

>>> src/calendar_date_alu.sv
`timescale 1ns / 1ps
// Channel  Handshake             Word
// in       in_valid / in_stall   opcode, year, month, day
// out      out_valid / out_stall year, month, day, weekday, bad-date flag
//
// Four register stages: divide-by-100 multiplies, leap/valid/Zeller sum,
// mod-7 multiply, date update into the output register.
// One word per cycle while out_stall is low; out_valid rises as the word enters res_r.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled output holds; upstream stages keep filling empty slots.

module calendar_date_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cda_pkg::OP_W-1:0]      in_opcode,
  input  logic [cda_pkg::YEAR_W-1:0]    in_year_in,
  input  logic [cda_pkg::MONTH_W-1:0]   in_month_in,
  input  logic [cda_pkg::DAY_W-1:0]     in_day_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cda_pkg::YEAR_W-1:0]    out_year_out,
  output logic [cda_pkg::MONTH_W-1:0]   out_month_out,
  output logic [cda_pkg::DAY_W-1:0]     out_day_out,
  output logic [cda_pkg::WDAY_W-1:0]    out_weekday,
  output logic                          out_bad_date
);
  import cda_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  res_t res_r, res_nxt;

  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // stage 1: shift months for Zeller, divide both years by 100
  logic              early;
  logic [PROD100_W-1:0] py, pz;

  always_comb begin
    early     = (in_month_in < MON_MAR);
    s1_nxt.op = in_opcode;
    s1_nxt.y  = in_year_in;
    s1_nxt.m  = in_month_in;
    s1_nxt.d  = in_day_in;
    s1_nxt.yz = early ? (in_year_in - 14'd1) : in_year_in;
    s1_nxt.mz = early ? (in_month_in + 4'd12) : in_month_in;
    py = PROD100_W'(in_year_in) * PROD100_W'(RECIP100_MUL);
    pz = PROD100_W'(s1_nxt.yz) * PROD100_W'(RECIP100_MUL);
    s1_nxt.qy = py[RECIP100_SH +: Q100_W];
    s1_nxt.qz = pz[RECIP100_SH +: Q100_W];
  end

  // stage 2: remainders, leap years, month lengths, validity, Zeller sum
  logic [YEAR_W-1:0] ry_full, rz_full;
  logic [R100_W-1:0] ry, k;
  logic              lp, lp_ny, cent_ny;
  logic [Q100_W-1:0] qy_ny;
  logic [ZSUM_W-1:0] j5;

  always_comb begin
    ry_full = s1_r.y  - (YEAR_W'(s1_r.qy) * 14'd100);
    rz_full = s1_r.yz - (YEAR_W'(s1_r.qz) * 14'd100);
    ry      = ry_full[R100_W-1:0];
    k       = rz_full[R100_W-1:0];
    lp      = ((s1_r.y[1:0] == 2'd0) && (ry != '0)) || ((ry == '0) && (s1_r.qy[1:0] == 2'd0));
    qy_ny   = s1_r.qy + 8'd1;
    cent_ny = (ry == 7'd99);
    lp_ny   = ((s1_r.y[1:0] == 2'd3) && !cent_ny) || (cent_ny && (qy_ny[1:0] == 2'd0));
    j5      = {1'b0, s1_r.qz, 2'b00} + ZSUM_W'(s1_r.qz);

    s2_nxt.op     = s1_r.op;
    s2_nxt.y      = s1_r.y;
    s2_nxt.m      = s1_r.m;
    s2_nxt.d      = s1_r.d;
    s2_nxt.len    = month_len(lp, s1_r.m);
    s2_nxt.len_nm = (s1_r.m == MON_DEC) ? DAY_JAN_LEN : month_len(lp, s1_r.m + MON_JAN);
    s2_nxt.len_ny = month_len(lp_ny, s1_r.m);
    // weekday offset of six folds Zeller's Saturday-first count into Sunday-first
    s2_nxt.h      = ZSUM_W'(s1_r.d) + ZSUM_W'(zeller_month(s1_r.mz)) + ZSUM_W'(k)
                  + ZSUM_W'(k[R100_W-1:2]) + ZSUM_W'(s1_r.qz[Q100_W-1:2]) + j5
                  + ZSUM_W'(6);
    s2_nxt.bad    = (s1_r.y == '0) || (s1_r.y > YEAR_MAX) || (s1_r.m == '0)
                  || (s1_r.m > MON_DEC) || (s1_r.d == '0) || (s1_r.d > s2_nxt.len);
  end

  // stage 3: reduce the Zeller sum mod 7
  logic [PROD7_W-1:0] p7;
  logic [ZSUM_W-1:0]  q7, r7;

  always_comb begin
    p7 = PROD7_W'(s2_r.h) * PROD7_W'(RECIP7_MUL);
    q7 = ZSUM_W'(p7[PROD7_W-1:RECIP7_SH]);
    r7 = s2_r.h - ZSUM_W'({q7, 3'b000} - {3'b000, q7});
    s3_nxt.op     = s2_r.op;
    s3_nxt.y      = s2_r.y;
    s3_nxt.m      = s2_r.m;
    s3_nxt.d      = s2_r.d;
    s3_nxt.len    = s2_r.len;
    s3_nxt.len_nm = s2_r.len_nm;
    s3_nxt.len_ny = s2_r.len_ny;
    s3_nxt.wd     = r7[WDAY_W-1:0];
    s3_nxt.bad    = s2_r.bad;
  end

  // stage 4: date update
  cda_calc u_calc (
    .s3_i  (s3_r),
    .res_o (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r  <= s1_nxt;
    if (rdy2 && v1_r)     s2_r  <= s2_nxt;
    if (rdy3 && v2_r)     s3_r  <= s3_nxt;
    if (rdy4 && v3_r)     res_r <= res_nxt;
  end

  assign out_valid     = v4_r;
  assign out_year_out  = res_r.year;
  assign out_month_out = res_r.month;
  assign out_day_out   = res_r.day;
  assign out_weekday   = res_r.weekday;
  assign out_bad_date  = res_r.bad;

endmodule

>>> dv/calendar_date_alu_test.sv
`timescale 1ns / 1ps

module calendar_date_alu_test;
  import cda_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_word_t;

  // opcodes outside the enum fall back to the weekday behavior
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int unsigned SUNDAY        = 0;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SHOWN_ERRORS  = 10;
  localparam int unsigned EDGE_YEARS [13] =
    '{1, 2, 4, 100, 400, 1600, 1900, 2000, 2100, 2400, 9996, 9998, 9999};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode = '0;
  logic [YEAR_W-1:0]   in_year_in = '0;
  logic [MONTH_W-1:0]  in_month_in = '0;
  logic [DAY_W-1:0]    in_day_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [YEAR_W-1:0]   out_year_out;
  logic [MONTH_W-1:0]  out_month_out;
  logic [DAY_W-1:0]    out_day_out;
  logic [WDAY_W-1:0]   out_weekday;
  logic                out_bad_date;

  date_word_t  pending_words[$];
  res_t        expected_dates[$];
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned dates_checked = 0;
  int unsigned bad_flags_seen = 0;
  int unsigned mismatches = 0;
  int unsigned op_seen [8] = '{default: 0};
  int unsigned phase = 0;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 71;
  int unsigned hold_left = 0;
  bit          held_off = 1'b0;

  calendar_date_alu dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_year_in    (in_year_in),
    .in_month_in   (in_month_in),
    .in_day_in     (in_day_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_year_out  (out_year_out),
    .out_month_out (out_month_out),
    .out_day_out   (out_day_out),
    .out_weekday   (out_weekday),
    .out_bad_date  (out_bad_date)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2:                     return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:           return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default:               return 0;
    endcase
  endfunction

  // Zeller's congruence, shifted so that 0 is Sunday
  function automatic int unsigned day_of_week(int unsigned y, int unsigned m, int unsigned d);
    int unsigned k, c, h;
    if (m < MON_MAR) begin
      m += 12;
      y -= 1;
    end
    k = y % 100;
    c = y / 100;
    h = (d + (13 * (m + 1)) / 5 + k + k / 4 + c / 4 + 5 * c) % DAYS_PER_WEEK;
    return (h + 6) % DAYS_PER_WEEK;
  endfunction

  function automatic res_t predict_date(date_word_t w);
    int unsigned y, m, d, wd, len;
    res_t r;
    y = w.year;
    m = w.month;
    d = w.day;
    wd = 0;
    r.bad = 1'b0;
    if (y < 1 || y > YEAR_MAX || m < MON_JAN || m > MON_DEC || d < 1 || d > month_days(y, m)) begin
      r.bad = 1'b1;
    end else begin
      wd = day_of_week(y, m, d);
      case (op_t'(w.op))
        OP_ADD_DAY: begin
          if (d < month_days(y, m)) begin
            d++;
          end else if (m == MON_DEC) begin
            y++;
            m = MON_JAN;
            d = DAY_FIRST;
          end else begin
            m++;
            d = DAY_FIRST;
          end
        end
        OP_ADD_MONTH: begin
          if (m == MON_DEC) begin
            y++;
            m = MON_JAN;
          end else begin
            m++;
          end
          len = month_days(y, m);
          if (d > len) d = len;
        end
        OP_ADD_YEAR: begin
          y++;
          len = month_days(y, m);
          if (d > len) d = len;
        end
        OP_NEXT_MON: begin
          d += (wd == SUNDAY) ? 1 : DAYS_PER_WEEK + 1 - wd;
          len = month_days(y, m);
          if (d > len) begin
            d -= len;
            if (m == MON_DEC) begin
              y++;
              m = MON_JAN;
            end else begin
              m++;
            end
          end
        end
        default: ;
      endcase
      if (y > YEAR_MAX) r.bad = 1'b1;
    end
    r.year    = YEAR_W'(y);
    r.month   = MONTH_W'(m);
    r.day     = DAY_W'(d);
    r.weekday = WDAY_W'(wd);
    return r;
  endfunction

  // mostly valid dates, biased toward month ends and century years
  function automatic date_word_t random_word();
    date_word_t w;
    int unsigned pick, len;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) w.op = OP_W'($urandom_range(OP_SPARE_7, OP_SPARE_5));
    else w.op = OP_W'($urandom_range(OP_NEXT_MON, OP_ADD_DAY));
    if (pick < 85) begin
      case ($urandom_range(3))
        0:       w.year = YEAR_W'(EDGE_YEARS[$urandom_range(12)]);
        1:       w.year = YEAR_W'($urandom_range(YEAR_MAX, YEAR_MAX - 9));
        default: w.year = YEAR_W'($urandom_range(YEAR_MAX, 1));
      endcase
      w.month = MONTH_W'($urandom_range(MON_DEC, MON_JAN));
      len = month_days(w.year, w.month);
      if ($urandom_range(1)) w.day = DAY_W'($urandom_range(len, len - 6));
      else w.day = DAY_W'($urandom_range(len, 1));
    end else if (pick < 93) begin
      w.year  = YEAR_W'($urandom_range(YEAR_MAX, 1));
      w.month = MONTH_W'($urandom_range(15, 0));
      if ($urandom_range(1)) w.day = DAY_W'(month_days(w.year, w.month) + 1);
      else w.day = '0;
    end else begin
      w.year  = YEAR_W'($urandom);
      w.month = MONTH_W'($urandom);
      w.day   = DAY_W'($urandom);
    end
    return w;
  endfunction

  task automatic queue_word(date_word_t w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // sender: hold a stalled word, otherwise pop the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_dates.push_back(predict_date('{in_opcode, in_year_in, in_month_in, in_day_in}));
        op_seen[in_opcode]++;
        words_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_opcode   <= pending_words[0].op;
          in_year_in  <= pending_words[0].year;
          in_month_in <= pending_words[0].month;
          in_day_in   <= pending_words[0].day;
          in_valid    <= 1'b1;
          void'(pending_words.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted result, then pick the next stall
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      dates_checked++;
      bad_flags_seen += out_bad_date;
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("%0t: unexpected result %0d-%0d-%0d wd %0d bad %0d", $realtime,
                   out_year_out, out_month_out, out_day_out, out_weekday, out_bad_date);
      end else begin
        want = expected_dates.pop_front();
        if (want.year != out_year_out || want.month != out_month_out ||
            want.day != out_day_out || want.weekday != out_weekday ||
            want.bad != out_bad_date) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("%0t: mismatch: expected %0d-%0d-%0d wd %0d bad %0d, got %0d-%0d-%0d wd %0d bad %0d",
                     $realtime, want.year, want.month, want.day, want.weekday, want.bad,
                     out_year_out, out_month_out, out_day_out, out_weekday, out_bad_date);
        end
      end
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rst_n && phase == 2 && !held_off && in_valid) begin
      // long hold so the pipe fills and backs up into the input
      hold_left = HOLD_CYCLES;
      held_off = 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    int unsigned settle;

    queue_word('{OP_ADD_DAY,   9999, 12, 31});
    queue_word('{OP_ADD_DAY,   2024,  2, 28});
    queue_word('{OP_ADD_DAY,   2023,  2, 28});
    queue_word('{OP_ADD_DAY,   2000,  2, 29});
    queue_word('{OP_ADD_DAY,   2023, 12, 31});
    queue_word('{OP_ADD_DAY,   1900,  2, 29});
    queue_word('{OP_ADD_MONTH, 2024,  1, 31});
    queue_word('{OP_ADD_MONTH, 2023,  1, 31});
    queue_word('{OP_ADD_MONTH, 9999, 12, 15});
    queue_word('{OP_ADD_YEAR,  2024,  2, 29});
    queue_word('{OP_ADD_YEAR,  9999,  6,  1});
    queue_word('{OP_WEEKDAY,      1,  1,  1});
    queue_word('{OP_WEEKDAY,      1,  2, 28});
    queue_word('{OP_NEXT_MON,  2024,  1,  1});
    queue_word('{OP_NEXT_MON,  2024,  1,  7});
    queue_word('{OP_NEXT_MON,  2024,  2, 27});
    queue_word('{OP_NEXT_MON,  9999, 12, 31});
    queue_word('{OP_ADD_DAY,      0,  5,  5});
    queue_word('{OP_ADD_MONTH, 16383, 1,  1});
    queue_word('{OP_ADD_YEAR,  2024,  0,  1});
    queue_word('{OP_NEXT_MON,  2024, 15,  1});
    queue_word('{OP_ADD_DAY,   2024,  4, 31});
    queue_word('{OP_WEEKDAY,   2024,  3,  0});
    queue_word('{OP_SPARE_5,   2024,  6, 15});
    queue_word('{OP_SPARE_7,   9999, 12, 31});
    repeat (380) queue_word(random_word());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (words_accepted != words_queued) @(posedge clk);

    phase = 1;
    send_idle_pct = 71;
    recv_idle_pct = 37;
    repeat (385) queue_word(random_word());
    while (words_accepted != words_queued) @(posedge clk);

    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (385) queue_word(random_word());
    while (words_accepted != words_queued) @(posedge clk);

    settle = 0;
    while (expected_dates.size() != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (12) @(posedge clk);
    if (expected_dates.size() != 0) begin
      $display("%0d expected results never arrived", expected_dates.size());
      mismatches += expected_dates.size();
    end

    $display("Covered %0d date words, %0d results checked (%0d flagged bad), %0d-cycle output hold",
             words_accepted, dates_checked, bad_flags_seen, HOLD_CYCLES);
    $display("Opcode mix day/month/year/weekday/next-Monday/spare: %0d/%0d/%0d/%0d/%0d/%0d",
             op_seen[OP_ADD_DAY], op_seen[OP_ADD_MONTH], op_seen[OP_ADD_YEAR],
             op_seen[OP_WEEKDAY], op_seen[OP_NEXT_MON],
             op_seen[OP_SPARE_5] + op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d of %0d words accepted", words_accepted, words_queued);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
